>>> src/audio_frame_preemphasis_window_core_assert.svh
// Assertion macros for the audio frame pre-emphasis and window core.
// Used by the top level only; expects clk and rst in scope.
`ifndef AUDIO_FRAME_PREEMPHASIS_WINDOW_CORE_ASSERT_SVH
`define AUDIO_FRAME_PREEMPHASIS_WINDOW_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AFPW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afpw: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define AFPW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afpw: next-cycle check failed");

`endif

>>> src/afpw_pkg.sv
// Shared types and constants for the audio frame pre-emphasis and window core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package afpw_pkg;

  localparam int RING_DEPTH = 512;
  localparam int RING_AW    = 9;
  localparam int LANES      = 8;
  localparam int LANE_AW    = 3;
  localparam int LEN_W      = 10;
  localparam int CNT_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int VAL_W      = 18;
  localparam int GRP_W      = 6;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(RING_DEPTH);

  // Input item kinds carried in tuser.
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_WIN     = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_LENGTH = 3'd0;
  localparam logic [2:0] REG_FFT_LENGTH   = 3'd1;
  localparam logic [2:0] REG_HOP_LENGTH   = 3'd2;
  localparam logic [2:0] REG_START_OFFSET = 3'd3;
  localparam logic [2:0] REG_FRAME_COUNT  = 3'd4;
  localparam logic [2:0] REG_PREEMPHASIS  = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0]    frame_length;
    logic [LEN_W-1:0]    fft_length;
    logic [LEN_W-1:0]    hop_length;
    logic [CNT_W-1:0]    start_offset;
    logic [CNT_W-1:0]    frame_count;
    logic [COEF_W-1:0]   preemphasis;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [RING_AW-1:0]  addr;
    logic [15:0]         data;
  } mem_wr_t;

  typedef struct packed {
    logic [RING_AW-1:0]  start;
    logic [CNT_W-1:0]    frame_index;
  } job_t;

endpackage

`default_nettype wire

>>> src/afpw_fifo.sv
// Two-entry job queue between the intake front and the frame engine.
// Depends on afpw_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module afpw_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  afpw_pkg::job_t     push_job,
  input  wire logic          pop,
  output afpw_pkg::job_t     head,
  output logic               not_empty,
  output logic [1:0]         level
);
  import afpw_pkg::*;

  job_t entry [2];
  logic rd_ptr;
  logic wr_ptr;

  assign head      = entry[rd_ptr];
  assign not_empty = (level != 2'd0);

  // Pointer and fill level update.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> src/afpw_front.sv
// Intake front: configuration registers, stream counters and frame trigger.
// Depends on afpw_pkg; feeds memory writes and frame jobs to the back end.
`timescale 1ns / 1ps
`default_nettype none

module afpw_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [47:0]       s_tdata,   // sample, win_index, win_coeff
  input  wire logic [1:0]        s_tuser,   // action
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              room,
  output afpw_pkg::cfg_t         regs,
  output afpw_pkg::mem_wr_t      ring_wr,
  output afpw_pkg::mem_wr_t      win_wr,
  output logic                   job_push,
  output afpw_pkg::job_t         job
);
  import afpw_pkg::*;

  logic [31:0]      seen, seen_next;
  logic [CNT_W-1:0] done, done_next;
  logic [LEN_W-1:0] cd, cd_next;

  logic             accept;
  logic [31:0]      acc;
  logic [31:0]      n;
  logic [31:0]      fl32;
  logic [LEN_W-1:0] hop_eff;
  logic             geo_ok;
  logic             fire;

  assign s_tready = room;
  assign accept   = s_tvalid && room;
  assign acc      = seen - {16'd0, regs.start_offset};
  assign n        = acc + 32'd1;
  assign fl32     = {22'd0, regs.frame_length};
  assign hop_eff  = (regs.hop_length == '0) ? LEN_W'(1) : regs.hop_length;
  assign geo_ok   = (regs.frame_length <= MAX_LEN) && (regs.frame_length <= regs.fft_length)
                    && (regs.fft_length <= MAX_LEN);

  assign job.start       = acc[RING_AW-1:0] + RING_AW'(1) - regs.frame_length[RING_AW-1:0];
  assign job.frame_index = done;

  // Item decode, counter updates and frame trigger.
  always_comb begin
    seen_next    = seen;
    done_next    = done;
    cd_next      = cd;
    fire         = 1'b0;
    job_push     = 1'b0;
    ring_wr.en   = 1'b0;
    ring_wr.addr = acc[RING_AW-1:0];
    ring_wr.data = s_tdata[15:0];
    win_wr.en    = 1'b0;
    win_wr.addr  = s_tdata[24:16];
    win_wr.data  = s_tdata[40:25];
    if (accept) begin
      case (s_tuser)
        ACT_WIN: begin
          win_wr.en = 1'b1;
        end
        ACT_RESTART: begin
          seen_next = '0;
          done_next = '0;
          cd_next   = '0;
        end
        ACT_SAMPLE: begin
          if (seen != 32'hFFFF_FFFF) begin
            seen_next = seen + 32'd1;
            if (seen >= {16'd0, regs.start_offset}) begin
              ring_wr.en = 1'b1;
              if ((regs.frame_length != '0) && (n >= fl32)) begin
                if ((n == fl32) || (cd <= LEN_W'(1))) begin
                  fire    = 1'b1;
                  cd_next = hop_eff;
                end else begin
                  cd_next = cd - LEN_W'(1);
                end
              end
              if (fire && (done < regs.frame_count) && geo_ok) begin
                job_push  = 1'b1;
                done_next = done + CNT_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration registers and stream counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_length <= LEN_W'(400);
      regs.fft_length   <= LEN_W'(512);
      regs.hop_length   <= LEN_W'(160);
      regs.start_offset <= '0;
      regs.frame_count  <= '0;
      regs.preemphasis  <= COEF_W'(31785);
      seen              <= '0;
      done              <= '0;
      cd                <= '0;
    end else begin
      seen <= seen_next;
      done <= done_next;
      cd   <= cd_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_LENGTH: regs.frame_length <= cfg_data[LEN_W-1:0];
          REG_FFT_LENGTH:   regs.fft_length   <= cfg_data[LEN_W-1:0];
          REG_HOP_LENGTH:   regs.hop_length   <= cfg_data[LEN_W-1:0];
          REG_START_OFFSET: regs.start_offset <= cfg_data;
          REG_FRAME_COUNT:  regs.frame_count  <= cfg_data;
          REG_PREEMPHASIS:  regs.preemphasis  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> src/afpw_back.sv
// Frame engine: sample ring and window memories, mean divider, filter and
// window datapath, and the row emitter. Depends on afpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afpw_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  afpw_pkg::cfg_t         regs,
  input  afpw_pkg::mem_wr_t      ring_wr,
  input  afpw_pkg::mem_wr_t      win_wr,
  input  wire logic              job_valid,
  input  afpw_pkg::job_t         job,
  output logic                   job_pop,
  output logic                   busy,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [167:0]           m_tdata,   // value0..value7, group_index, frame_index
  output logic                   m_tlast    // row_last
);
  import afpw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_DIV, ST_MEAN, ST_POS, ST_MUL1, ST_DIFF,
    ST_WLO, ST_WHI, ST_ADD, ST_RND, ST_GROUP
  } state_t;

  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [COEF_W-1:0]   wtab [RING_DEPTH];
  logic [SAMPLE_W-1:0] ring_q;
  logic [COEF_W-1:0]   win_q;
  logic [RING_AW-1:0]  ring_raddr;

  state_t               state;
  logic [RING_AW-1:0]   start;
  logic [CNT_W-1:0]     fidx;
  logic [LEN_W-1:0]     cnt;
  logic                 rd_v;
  logic signed [24:0]   sum;
  logic [24:0]          mag;
  logic [24:0]          quo;
  logic [LEN_W-1:0]     rem;
  logic                 neg;
  logic [4:0]           bitcnt;
  logic signed [16:0]   mean;
  logic signed [33:0]   p2;
  logic [LEN_W-1:0]     pos;
  logic [LEN_W-1:0]     j;
  logic signed [15:0]   xp;
  logic signed [15:0]   x;
  logic [COEF_W-1:0]    w;
  logic signed [32:0]   p1;
  logic signed [33:0]   t;
  logic [32:0]          plo;
  logic signed [33:0]   phi;
  logic signed [50:0]   prod;
  logic [VAL_W-1:0]     lanes [LANES];
  logic [VAL_W-1:0]     out_val [LANES];
  logic [GRP_W-1:0]     out_grp;
  logic [CNT_W-1:0]     out_frame;
  logic                 out_last;

  logic [LEN_W:0]       rem_sh;
  logic [LEN_W-1:0]     left;
  logic [6:0]           groups;
  logic                 in_frame;
  logic                 grp_done;
  logic                 row_end;
  logic                 emit;
  logic [16:0]          q17;
  logic signed [16:0]   mean_v;
  logic signed [16:0]   omc;
  logic signed [33:0]   x_sh;
  logic signed [33:0]   m_sh;
  logic signed [33:0]   t_v;
  logic signed [50:0]   sumr;
  logic signed [20:0]   r21;
  logic [VAL_W-1:0]     sat_v;

  assign busy       = (state != ST_IDLE);
  assign job_pop    = (state == ST_IDLE) && job_valid;
  assign ring_raddr = (state == ST_SUM) ? start + cnt[RING_AW-1:0] : start + j[RING_AW-1:0];

  // Row geometry and per-position classification.
  assign left     = (regs.fft_length - regs.frame_length) >> 1;
  assign groups   = 7'((11'(regs.fft_length) + 11'(LANES - 1)) >> LANE_AW);
  assign in_frame = (pos < regs.fft_length) && (pos >= left)
                    && ((pos - left) < regs.frame_length);
  assign grp_done = (pos[LANE_AW-1:0] == LANE_AW'(LANES - 1));
  assign row_end  = (7'(pos[LEN_W-2:LANE_AW]) + 7'd1 == groups);

  // A finished group moves to the output register when that register is free.
  assign emit = (state == ST_GROUP) && (!m_tvalid || m_tready);

  // Divider step, mean and the filter difference.
  always_comb begin
    rem_sh = {rem, mag[24]};
    q17    = quo[16:0];
    mean_v = neg ? -$signed(q17) : $signed(q17);
    omc    = 17'sd32768 - $signed({1'b0, regs.preemphasis});
    x_sh   = 34'(x) <<< 15;
    m_sh   = 34'(mean) <<< 15;
    t_v    = (j == '0) ? (x_sh - m_sh) : (x_sh - 34'(p1) - p2);
  end

  // Round half away from zero and saturate to Q2.15.
  always_comb begin
    sumr = prod + (prod[50] ? 51'sd536870911 : 51'sd536870912);
    r21  = sumr[50:30];
    if (r21 > 21'sd131071) begin
      sat_v = VAL_W'(131071);
    end else if (r21 < -21'sd131072) begin
      sat_v = VAL_W'(-131072);
    end else begin
      sat_v = r21[VAL_W-1:0];
    end
  end

  // Sample ring: written by the front, read here with registered data.
  always_ff @(posedge clk) begin
    if (ring_wr.en) begin
      ring[ring_wr.addr] <= ring_wr.data;
    end
    ring_q <= ring[ring_raddr];
  end

  // Window table.
  always_ff @(posedge clk) begin
    if (win_wr.en) begin
      wtab[win_wr.addr] <= win_wr.data;
    end
    win_q <= wtab[j[RING_AW-1:0]];
  end

  // Sequencer with datapath and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            start <= job.start;
            fidx  <= job.frame_index;
            cnt   <= '0;
            rd_v  <= 1'b0;
            sum   <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (cnt != regs.frame_length) begin
            cnt <= cnt + LEN_W'(1);
          end
          rd_v <= (cnt != regs.frame_length);
          if (rd_v) begin
            sum <= sum + 25'($signed(ring_q));
          end
          if ((cnt == regs.frame_length) && !rd_v) begin
            mag    <= sum[24] ? (~sum + 25'd1) : sum;
            neg    <= sum[24];
            rem    <= '0;
            quo    <= '0;
            bitcnt <= '0;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_sh >= {1'b0, regs.frame_length}) begin
            rem <= LEN_W'(rem_sh - {1'b0, regs.frame_length});
            quo <= {quo[23:0], 1'b1};
          end else begin
            rem <= rem_sh[LEN_W-1:0];
            quo <= {quo[23:0], 1'b0};
          end
          mag    <= {mag[23:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'd24) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean  <= mean_v;
          p2    <= mean_v * omc;
          pos   <= '0;
          j     <= '0;
          state <= ST_POS;
        end
        ST_POS: begin
          if (in_frame) begin
            state <= ST_MUL1;
          end else begin
            lanes[pos[LANE_AW-1:0]] <= '0;
            if (grp_done) begin
              state <= ST_GROUP;
            end else begin
              pos <= pos + LEN_W'(1);
            end
          end
        end
        ST_MUL1: begin
          x     <= $signed(ring_q);
          w     <= win_q;
          p1    <= $signed({1'b0, regs.preemphasis}) * xp;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          t     <= t_v;
          state <= ST_WLO;
        end
        ST_WLO: begin
          plo   <= 33'(t[16:0]) * 33'(w);
          state <= ST_WHI;
        end
        ST_WHI: begin
          phi   <= $signed(t[33:17]) * $signed({1'b0, w});
          state <= ST_ADD;
        end
        ST_ADD: begin
          prod  <= (51'(phi) <<< 17) + $signed({18'd0, plo});
          state <= ST_RND;
        end
        ST_RND: begin
          lanes[pos[LANE_AW-1:0]] <= sat_v;
          xp <= x;
          j  <= j + LEN_W'(1);
          if (grp_done) begin
            state <= ST_GROUP;
          end else begin
            pos   <= pos + LEN_W'(1);
            state <= ST_POS;
          end
        end
        ST_GROUP: begin
          if (emit) begin
            out_val   <= lanes;
            out_grp   <= pos[LEN_W-2:LANE_AW];
            out_frame <= fidx;
            out_last  <= row_end;
            if (row_end) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos + LEN_W'(1);
              state <= ST_POS;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output packing.
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < LANES; k++) begin
      m_tdata[k*VAL_W +: VAL_W] = out_val[k];
    end
    m_tdata[LANES*VAL_W +: GRP_W]         = out_grp;
    m_tdata[LANES*VAL_W + GRP_W +: CNT_W] = out_frame;
    m_tlast = out_last;
  end

endmodule

`default_nettype wire

>>> src/audio_frame_preemphasis_window_core.sv
// Top level of the STFT framing core with mean removal, pre-emphasis and window.
// Instantiates afpw_front, afpw_fifo and afpw_back; uses afpw_pkg and the assert header.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tdata sample,win_index,win_coeff; tuser action
//   m_*       out        m_tvalid/m_tready  tdata value0..7,group_index,frame_index; tlast
//   cfg_*     in         cfg_we             cfg_index, cfg_data
//
// A sample that starts no row, a window write or a restart leaves intake ready.
// A row picks up the job, sums the ring, runs the mean divider and forms the mean,
// then filters and windows each frame sample, zeroes each padding slot and emits
// each group of eight, waiting out any output stall; intake waits until the last
// group of the row is loaded into the output register.
// Reset (rst, synchronous) clears counters and control; the memories keep contents.
`timescale 1ns / 1ps
`default_nettype none

module audio_frame_preemphasis_window_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [47:0]   s_tdata,   // sample, win_index, win_coeff
  input  wire logic [1:0]    s_tuser,   // action
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [167:0]       m_tdata,   // value0..value7, group_index, frame_index
  output logic               m_tlast,   // row_last
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import afpw_pkg::*;

  cfg_t    regs;
  mem_wr_t ring_wr;
  mem_wr_t win_wr;
  job_t    job;
  job_t    head;
  logic    job_push;
  logic    job_pop;
  logic    q_not_empty;
  logic [1:0] q_level;
  logic    back_busy;
  logic    room;

  // Intake pauses while a frame is queued or being processed.
  assign room = !q_not_empty && !back_busy;

  afpw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room      (room),
    .regs      (regs),
    .ring_wr   (ring_wr),
    .win_wr    (win_wr),
    .job_push  (job_push),
    .job       (job)
  );

  afpw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (job),
    .pop       (job_pop),
    .head      (head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  afpw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .ring_wr   (ring_wr),
    .win_wr    (win_wr),
    .job_valid (q_not_empty),
    .job       (head),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Checks on the hand-off between front and back.
`include "audio_frame_preemphasis_window_core_assert.svh"
  `AFPW_ASSERT_IMP(a_push_on_accept, job_push, s_tvalid && s_tready)
  `AFPW_ASSERT_NXT(a_stall_after_push, job_push, !s_tready)
  `AFPW_ASSERT_IMP(a_queue_shallow, q_not_empty, q_level == 2'd1)
  `AFPW_ASSERT_IMP(a_busy_blocks_intake, back_busy, !s_tready)

endmodule

`default_nettype wire

>>> sim/audio_frame_preemphasis_window_core_tb.sv
// Self-checking testbench for the STFT framing core with mean removal and window.
// Needs afpw_pkg and audio_frame_preemphasis_window_core; a built-in predictor checks every group.
`timescale 1ns / 1ps
`default_nettype none

module audio_frame_preemphasis_window_core_tb;
  import afpw_pkg::*;

  // Action code 3 is ignored by the block.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Window entries written before any frame; no setting below that yields frames uses a longer one.
  localparam int WIN_FILL = 32;

  // One output group: lane values, group number, frame number and row end.
  typedef struct packed {
    logic        last;
    logic [15:0] fidx;
    logic [5:0]  grp;
    logic [143:0] vals;
  } group_t;

  // One configuration setting and how many random items run under it.
  typedef struct {
    int fl, fft, hop, off, cnt, pre, n;
    bit restarts;
  } setting_t;

  // One directed item and the number of groups it should produce.
  typedef struct {
    logic [1:0]  act;
    logic [15:0] smp;
    logic [8:0]  widx;
    logic [15:0] wcoef;
    int          groups;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // sample, win_index, win_coeff
  logic [1:0]   s_tuser = '0;   // action
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;        // value0..value7, group_index, frame_index
  logic         m_tlast;        // row_last
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  audio_frame_preemphasis_window_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and its copy of the registers.
  logic [15:0] ring_mem [RING_DEPTH];
  logic [15:0] win_mem [RING_DEPTH];
  longint      row_val [RING_DEPTH];
  int unsigned seen_cnt, hop_cd, done_cnt;
  int unsigned frame_len = 400, fft_len = 512, hop_len = 160;
  int unsigned start_off = 0, frame_cnt = 0, pre_coef = 31785;

  group_t expected_groups[$];
  int     fail_cnt = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Works out the groups that one accepted item causes.
  task automatic predict_item(input logic [1:0] act, input logic [15:0] smp,
                              input logic [8:0] widx, input logic [15:0] wcoef,
                              output int groups);
    int unsigned acc, n, hop, fst, lft, grps, p;
    longint sum, mean, x, xp, t, pr, r;
    bit fire;
    group_t e;
    groups = 0;
    case (act)
      ACT_WIN: win_mem[widx] = wcoef;
      ACT_RESTART: begin
        seen_cnt = 0;
        done_cnt = 0;
        hop_cd = 0;
      end
      ACT_SAMPLE: begin
        if (seen_cnt == 32'hFFFF_FFFF) return;
        if (seen_cnt < start_off) begin
          seen_cnt++;
          return;
        end
        acc = seen_cnt - start_off;
        ring_mem[acc % RING_DEPTH] = smp;
        seen_cnt++;
        hop = (hop_len != 0) ? hop_len : 1;
        n = acc + 1;
        if (frame_len == 0 || n < frame_len) return;
        fire = 1'b0;
        if (n == frame_len) begin
          fire = 1'b1;
          hop_cd = hop;
        end else if (hop_cd > 1) begin
          hop_cd--;
        end else begin
          fire = 1'b1;
          hop_cd = hop;
        end
        if (!fire || done_cnt >= frame_cnt) return;
        if (frame_len > RING_DEPTH || frame_len > fft_len || fft_len > RING_DEPTH) return;

        // Frame mean, truncated toward zero.
        fst = acc + 1 - frame_len;
        sum = 0;
        for (int j = 0; j < frame_len; j++)
          sum += longint'($signed(ring_mem[(fst + j) % RING_DEPTH]));
        mean = sum / longint'(frame_len);

        // Pre-emphasis, window, rounding half away from zero and saturation.
        for (int j = 0; j < frame_len; j++) begin
          x = longint'($signed(ring_mem[(fst + j) % RING_DEPTH]));
          if (j == 0) begin
            t = (x - mean) * 32768;
          end else begin
            xp = longint'($signed(ring_mem[(fst + j - 1) % RING_DEPTH]));
            t = x * 32768 - longint'(pre_coef) * xp - mean * (32768 - longint'(pre_coef));
          end
          pr = t * longint'(win_mem[j]);
          if (pr >= 0) r = (pr + 64'sd536870912) >>> 30;
          else r = -((-pr + 64'sd536870912) >>> 30);
          if (r > 131071) r = 131071;
          if (r < -131072) r = -131072;
          row_val[j] = r;
        end

        // Centered row with zero padding, in groups of eight lanes.
        lft = (fft_len - frame_len) / 2;
        grps = (fft_len + LANES - 1) / LANES;
        for (int g = 0; g < grps; g++) begin
          e.vals = '0;
          for (int k = 0; k < LANES; k++) begin
            p = g * LANES + k;
            if (p < fft_len && p >= lft && p - lft < frame_len)
              e.vals[18*k +: 18] = row_val[p - lft][17:0];
          end
          e.grp = 6'(g);
          e.fidx = 16'(done_cnt);
          e.last = (g + 1 == grps);
          expected_groups.push_back(e);
        end
        done_cnt = (done_cnt + 1) & 16'hFFFF;
        groups = grps;
      end
      default: ;
    endcase
  endtask

  // Sends one item, with a random idle gap first, and predicts on acceptance.
  task automatic send_item(input logic [1:0] act, input logic [15:0] smp,
                           input logic [8:0] widx, input logic [15:0] wcoef,
                           output int groups);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {7'b0, wcoef, widx, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(act, smp, widx, wcoef, groups);
  endtask

  // Writes all six registers on consecutive cycles while the block is idle.
  task automatic program_regs(input setting_t st);
    int vals[6];
    vals = '{st.fl, st.fft, st.hop, st.off, st.cnt, st.pre};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 16'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    frame_len = vals[REG_FRAME_LENGTH] & 10'h3FF;
    fft_len = vals[REG_FFT_LENGTH] & 10'h3FF;
    hop_len = vals[REG_HOP_LENGTH] & 10'h3FF;
    start_off = vals[REG_START_OFFSET] & 16'hFFFF;
    frame_cnt = vals[REG_FRAME_COUNT] & 16'hFFFF;
    pre_coef = vals[REG_PREEMPHASIS] & 16'hFFFF;
  endtask

  // Lets every expected group arrive, then waits out a possible silent frame.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (6000) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
  endfunction

  // Receiver: compares each accepted group with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_groups.size() == 0) begin
          note_fail($sformatf("unexpected group data=%h last=%b", m_tdata, m_tlast));
        end else begin
          automatic group_t e = expected_groups.pop_front();
          for (int k = 0; k < LANES; k++)
            if (m_tdata[18*k +: 18] !== e.vals[18*k +: 18])
              note_fail($sformatf("frame %0d group %0d value%0d exp %h got %h",
                                  e.fidx, e.grp, k, e.vals[18*k +: 18], m_tdata[18*k +: 18]));
          if (m_tdata[144 +: 6] !== e.grp)
            note_fail($sformatf("group_index exp %0d got %0d", e.grp, m_tdata[144 +: 6]));
          if (m_tdata[150 +: 16] !== e.fidx)
            note_fail($sformatf("frame_index exp %0d got %0d", e.fidx, m_tdata[150 +: 16]));
          if (m_tlast !== e.last)
            note_fail($sformatf("row_last exp %b got %b (group %0d)", e.last, m_tlast, e.grp));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Directed items under a four-sample frame in an eight-wide row, hop one,
  // two skipped samples and a coefficient of one.
  dir_row_t dir_rows[] = '{
    '{ACT_RESTART, 16'h0000, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h1234, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h8000, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h7FFF, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h8000, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h7FFF, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h8000, 9'd0, 16'h0000, 1},
    '{ACT_SAMPLE,  16'h0000, 9'd0, 16'h0000, 1},
    '{ACT_SAMPLE,  16'hFFFF, 9'd0, 16'h0000, 1},
    '{ACT_WIN,     16'h0000, 9'd511, 16'hFFFF, 0},
    '{ACT_WIN,     16'h0000, 9'd1, 16'h0000, 0},
    '{ACT_NONE,    16'hFFFF, 9'd511, 16'hFFFF, 0},
    '{ACT_SAMPLE,  16'h7FFF, 9'd0, 16'h0000, 1},
    '{ACT_SAMPLE,  16'h7FFF, 9'd0, 16'h0000, 1},
    '{ACT_WIN,     16'h0000, 9'd1, 16'h8000, 0},
    '{ACT_RESTART, 16'h0000, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h0005, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h0005, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h0064, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'hFF9C, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'h0007, 9'd0, 16'h0000, 0},
    '{ACT_SAMPLE,  16'hFFF9, 9'd0, 16'h0000, 1}
  };

  // Settings for the random part: padded rows, hop of zero, ragged rows, bad
  // geometry, widest rows, a long hop, a skip and the reset values.
  setting_t settings[] = '{
    '{16, 24, 5, 3, 65535, 31785, 60, 1'b1},
    '{1, 8, 0, 0, 40, 0, 30, 1'b1},
    '{10, 13, 3, 0, 65535, 65535, 40, 1'b1},
    '{20, 16, 2, 0, 65535, 20000, 10, 1'b1},
    '{0, 8, 1, 0, 65535, 20000, 10, 1'b1},
    '{8, 600, 1, 0, 65535, 20000, 10, 1'b1},
    '{600, 1023, 1, 0, 65535, 20000, 10, 1'b1},
    '{32, 512, 1, 0, 2, 32768, 36, 1'b0},
    '{8, 8, 1, 1, 65535, 12345, 40, 1'b1},
    '{2, 8, 25, 0, 65535, 31785, 30, 1'b0},
    '{1, 8, 1, 40, 3, 16384, 50, 1'b0},
    '{400, 512, 160, 0, 0, 31785, 10, 1'b1}
  };

  initial begin
    int groups, sel;
    logic [1:0] act;
    logic [15:0] smp;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the window entries that the frames below read.
    for (int i = 0; i < WIN_FILL; i++)
      send_item(ACT_WIN, 16'($urandom), 9'(i), rand_coef(), groups);
    drain();

    program_regs('{4, 8, 1, 2, 65535, 32768, 0, 1'b0});
    for (int i = 0; i < dir_rows.size(); i++) begin
      send_item(dir_rows[i].act, dir_rows[i].smp, dir_rows[i].widx, dir_rows[i].wcoef,
                groups);
      if (groups != dir_rows[i].groups)
        note_fail($sformatf("directed item %0d: exp %0d groups, predicted %0d",
                            i, dir_rows[i].groups, groups));
    end
    drain();

    foreach (settings[s]) begin
      program_regs(settings[s]);
      send_item(ACT_RESTART, 16'h0, 9'h0, 16'h0, groups);
      for (int i = 0; i < settings[s].n; i++) begin
        // Rotate idling: none, sender idle, receiver stall, both lightly.
        case ((i / 10) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
          default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
        sel = $urandom_range(99);
        case ($urandom_range(9))
          0: smp = 16'h7FFF;
          1: smp = 16'h8000;
          default: smp = 16'($urandom);
        endcase
        if (sel < 88 || !settings[s].restarts) act = ACT_SAMPLE;
        else if (sel < 94) act = ACT_WIN;
        else if (sel < 97) act = ACT_RESTART;
        else act = ACT_NONE;
        send_item(act, smp, 9'($urandom_range(511)), rand_coef(), groups);
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
